FILE: src/fmd_pkg.sv
package fmd_pkg;

    localparam int EXP_W  = 11;
    localparam int EXP_BIAS = 1023;
    localparam int EXP_MAX  = 2047;
    localparam int OUT_MANT_W = 53;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_ZERO      = 3'd1,
        ST_DIV_ZERO  = 3'd2,
        ST_OVERFLOW  = 3'd3,
        ST_UNDERFLOW = 3'd4
    } status_t;

    typedef struct packed {
        logic            func;
        logic            sign;
        logic [EXP_W-1:0] a_exp;
        logic [EXP_W-1:0] b_exp;
        status_t         early;
        logic            early_hit;
    } ctl_t;

endpackage

FILE: src/fmd_div_stage.sv
module fmd_div_stage #(
    parameter int MANT_WIDTH = 53
) (
    input  logic [MANT_WIDTH+1:0] rem_in,
    input  logic [MANT_WIDTH:0]   q_in,
    input  logic [MANT_WIDTH-1:0] divisor,
    output logic [MANT_WIDTH+1:0] rem_out,
    output logic [MANT_WIDTH:0]   q_out
);
    logic                  ge;
    logic [MANT_WIDTH+1:0] diff;

    always_comb
    begin
        ge = rem_in >= {2'b00, divisor};
        diff = ge ? (rem_in - {2'b00, divisor}) : rem_in;
        rem_out = {diff[MANT_WIDTH:0], 1'b0};
        q_out = {q_in[MANT_WIDTH-1:0], ge};
    end
endmodule

FILE: src/float_mul_div_unit_top.sv
// channel  dir  fields (tdata lsb up)
// s_axis   in   func, a_sign, a_exp, a_mant, b_sign, b_exp, b_mant
// m_axis   out  r_sign, r_exp, r_mant, status
// one word per cycle while m_axis is not stalled; the divider takes one divide step per stage
// multiply product is formed in four half-width partial products, summed in the next stage
// rst_n clears all valid bits; payload registers are not reset
// a stall on m_axis holds every stage; s_axis_tready follows the output stage
module float_mul_div_unit_top #(
    parameter int MANT_WIDTH = 53
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [135:0] s_axis_tdata,  // func, a_sign, a_exp, a_mant, b_sign, b_exp, b_mant
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [71:0]  m_axis_tdata   // r_sign, r_exp, r_mant, status
);
    import fmd_pkg::*;

    localparam int W = MANT_WIDTH;
    localparam int DEPTH = W + 5;
    localparam int HW = (W + 1) / 2;
    localparam int LW = W - HW;

    logic adv;
    assign adv = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;

    // input decode
    logic          in_func, in_as, in_bs;
    logic [10:0]   in_ae, in_be;
    logic [W-1:0]  in_am, in_bm;
    ctl_t          in_ctl;
    always_comb
    begin
        in_func = s_axis_tdata[0];
        in_as = s_axis_tdata[1];
        in_ae = s_axis_tdata[12:2];
        in_am = s_axis_tdata[13 +: W];
        in_bs = s_axis_tdata[66];
        in_be = s_axis_tdata[77:67];
        in_bm = s_axis_tdata[78 +: W];
        in_ctl.func = in_func;
        in_ctl.sign = in_as ^ in_bs;
        in_ctl.a_exp = in_ae;
        in_ctl.b_exp = in_be;
        in_ctl.early_hit = (in_func && in_bm == '0) || in_am == '0 || in_bm == '0;
        in_ctl.early = (in_func && in_bm == '0) ? ST_DIV_ZERO : ST_ZERO;
    end

    // pipeline arrays
    logic [DEPTH-1:0] vld_reg;
    ctl_t             ctl_reg [DEPTH];
    logic [W-1:0]     am_reg  [DEPTH];
    logic [W-1:0]     bm_reg  [DEPTH];
    logic [W+1:0]     rem_reg [DEPTH];
    logic [W:0]       q_reg   [DEPTH];
    logic [W+1:0]     rem_next [DEPTH];
    logic [W:0]       q_next   [DEPTH];

    // multiply partials
    logic [2*HW-1:0]  pp_hh_reg, pp_hl_reg, pp_lh_reg, pp_ll_reg;
    logic [2*W-1:0]   prod_reg [DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[DEPTH-2:0], s_axis_tvalid};
    end

    assign rem_next[0] = {2'b00, in_am};
    assign q_next[0] = '0;

    genvar g;
    generate
        for (g = 1; g <= W + 1; g++)
        begin : g_div
            fmd_div_stage #(.MANT_WIDTH(W)) u_step (
                .rem_in (rem_reg[g-1]),
                .q_in   (q_reg[g-1]),
                .divisor(bm_reg[g-1]),
                .rem_out(rem_next[g]),
                .q_out  (q_next[g])
            );
        end
        for (g = W + 2; g < DEPTH; g++)
        begin : g_pass
            assign rem_next[g] = rem_reg[g-1];
            assign q_next[g] = q_reg[g-1];
        end
    endgenerate

    logic [2*W-1:0] prod_sum;
    assign prod_sum = ({{(2*W-2*HW){1'b0}}, pp_hh_reg} << (2*LW))
                    + ({{(2*W-2*HW){1'b0}}, pp_hl_reg} << LW)
                    + ({{(2*W-2*HW){1'b0}}, pp_lh_reg} << LW)
                    + {{(2*W-2*HW){1'b0}}, pp_ll_reg};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctl_reg[0] <= in_ctl;
            am_reg[0] <= in_am;
            bm_reg[0] <= in_bm;
            rem_reg[0] <= rem_next[0];
            q_reg[0] <= q_next[0];
            for (int i = 1; i < DEPTH; i++)
            begin
                ctl_reg[i] <= ctl_reg[i-1];
                am_reg[i] <= am_reg[i-1];
                bm_reg[i] <= bm_reg[i-1];
                rem_reg[i] <= rem_next[i];
                q_reg[i] <= q_next[i];
            end
            pp_hh_reg <= (2*HW)'({{(HW-LW){1'b0}}, am_reg[0][W-1:LW]} * bm_reg[0][W-1:LW]);
            pp_hl_reg <= (2*HW)'(am_reg[0][W-1:LW] * {{(HW-LW){1'b0}}, bm_reg[0][LW-1:0]});
            pp_lh_reg <= (2*HW)'({{(HW-LW){1'b0}}, am_reg[0][LW-1:0]} * bm_reg[0][W-1:LW]);
            pp_ll_reg <= (2*HW)'({{(HW-LW){1'b0}}, am_reg[0][LW-1:0]} * bm_reg[0][LW-1:0]);
            prod_reg[0] <= prod_sum;
            for (int i = 1; i < DEPTH; i++)
                prod_reg[i] <= prod_reg[i-1];
        end
    end

    // final normalize from stage DEPTH-2 into output register
    localparam int L = DEPTH - 2;
    ctl_t          fc;
    logic [W:0]    fq;
    logic [2*W-1:0] fp;
    logic signed [13:0] e;
    logic [W-1:0]  m;
    status_t       st;
    logic [71:0]   out_next;
    always_comb
    begin
        fc = ctl_reg[L];
        fq = q_reg[L];
        fp = prod_reg[L - 2];
        if (!fc.func)
        begin
            e = 14'(signed'({3'b0, fc.a_exp})) + 14'(signed'({3'b0, fc.b_exp}))
              - 14'(EXP_BIAS);
            if (fp[2*W-1])
            begin
                e = e + 14'sd1;
                m = fp[2*W-1:W];
            end
            else
                m = fp[2*W-2:W-1];
        end
        else
        begin
            e = 14'(signed'({3'b0, fc.a_exp})) - 14'(signed'({3'b0, fc.b_exp}))
              + 14'(EXP_BIAS);
            if (fq[W])
                m = fq[W:1];
            else
            begin
                e = e - 14'sd1;
                m = fq[W-1:0];
            end
        end
        if (fc.early_hit)
            st = fc.early;
        else if (e > 14'(EXP_MAX))
            st = ST_OVERFLOW;
        else if (e < 14'sd0)
            st = ST_UNDERFLOW;
        else if (m == '0)
            st = ST_ZERO;
        else
            st = ST_OK;
        out_next = '0;
        out_next[67:65] = st;
        if (st == ST_OK)
        begin
            out_next[0] = fc.sign;
            out_next[11:1] = e[10:0];
            out_next[12 +: W] = m;
        end
    end

    logic [71:0] out_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
            out_reg <= out_next;
    end
    assign m_axis_tdata = out_reg;
    assign m_axis_tvalid = vld_reg[DEPTH-1];

`ifndef SYNTHESIS
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[67:65] <= 3'd4)
        else $error("status out of range");
    a_err_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[67:65] != ST_OK) |-> m_axis_tdata[64:0] == '0)
        else $error("error result not cleared");
    a_ok_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[67:65] == ST_OK) |-> m_axis_tdata[64:12] != '0)
        else $error("ok result with zero mantissa");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("pipeline moved during stall");
`endif
endmodule
